/* rtl/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// Shared sizes, filter codes and the queue item of the scanline unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

   localparam int PIXEL_BYTES = 4;
   localparam int MAX_WIDTH   = 4096;
   localparam int LINE_BYTES  = MAX_WIDTH * PIXEL_BYTES;

   localparam int COL_W  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
   localparam int ROWB_W = $clog2(LINE_BYTES + 1);
   localparam int LANE_W = (PIXEL_BYTES > 1) ? $clog2(PIXEL_BYTES) : 1;

   localparam int WIDTH_W     = 13;
   localparam int HEIGHT_W    = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      FLT_NONE  = 3'd0,
      FLT_SUB   = 3'd1,
      FLT_UP    = 3'd2,
      FLT_AVG   = 3'd3,
      FLT_PAETH = 3'd4,
      FLT_BAD   = 3'd5
   } filter_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0]        data;
      filter_code_type   filter;
      logic [COL_W-1:0]  col;
      logic [LANE_W-1:0] lane;
      logic              first_px;
      logic              first_row;
      logic              last_col;
      logic              last_row;
   } item_type;

endpackage

`default_nettype wire

/* rtl/psu_ram.sv */
// ----------------------------------------------------------------------------
// psu_ram
// Generic single write, single read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/psu_front.sv */
// ----------------------------------------------------------------------------
// psu_front
// Takes stream beats, tracks row position and filter type, queues data bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_front
   import psu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,
   input  wire logic                   q_full,
   output logic                        q_push,
   output item_type                    q_item
);

   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic                await_ff, await_in;
   filter_code_type     filter_ff, filter_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [LANE_W-1:0]   lane_ff, lane_in;
   logic                first_px_ff, first_px_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;

   logic                accept;
   logic [ROWB_W-1:0]   eff_width;
   logic [ROWB_W-1:0]   row_bytes;
   logic [HEIGHT_W:0]   eff_height;
   logic                last_col;
   logic                last_row;
   logic                lane_wrap;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      priority if (width_ff == '0) begin
         eff_width = ROWB_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_width = ROWB_W'(MAX_WIDTH);
      end else begin
         eff_width = ROWB_W'(width_ff);
      end
      row_bytes  = ROWB_W'(eff_width * ROWB_W'(PIXEL_BYTES));
      eff_height = (height_ff == '0) ? (HEIGHT_W+1)'(1) : {1'b0, height_ff};
      last_col   = (ROWB_W'(col_ff) + ROWB_W'(1)) >= row_bytes;
      last_row   = ({1'b0, row_ff} + (HEIGHT_W+1)'(1)) >= eff_height;
      lane_wrap  = lane_ff == LANE_W'(PIXEL_BYTES - 1);
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      await_in    = await_ff;
      filter_in   = filter_ff;
      col_in      = col_ff;
      lane_in     = lane_ff;
      first_px_in = first_px_ff;
      row_in      = row_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         if (await_ff) begin
            filter_in   = (req_tdata > 8'd4) ? FLT_BAD : filter_code_type'(req_tdata[2:0]);
            col_in      = '0;
            lane_in     = '0;
            first_px_in = 1'b1;
            await_in    = 1'b0;
         end else if (last_col) begin
            await_in = 1'b1;
            col_in   = '0;
            row_in   = last_row ? '0 : row_ff + HEIGHT_W'(1);
         end else begin
            col_in  = col_ff + COL_W'(1);
            lane_in = lane_wrap ? '0 : lane_ff + LANE_W'(1);
            if (lane_wrap) begin
               first_px_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_W'(1);
         height_ff   <= HEIGHT_W'(1);
         await_ff    <= 1'b1;
         filter_ff   <= FLT_NONE;
         col_ff      <= '0;
         lane_ff     <= '0;
         first_px_ff <= 1'b1;
         row_ff      <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         await_ff    <= await_in;
         filter_ff   <= filter_in;
         col_ff      <= col_in;
         lane_ff     <= lane_in;
         first_px_ff <= first_px_in;
         row_ff      <= row_in;
      end
   end

   assign q_push = accept && !await_ff;

   always_comb begin
      q_item.data      = req_tdata;
      q_item.filter    = filter_ff;
      q_item.col       = col_ff;
      q_item.lane      = lane_ff;
      q_item.first_px  = first_px_ff;
      q_item.first_row = row_ff == '0;
      q_item.last_col  = last_col;
      q_item.last_row  = last_row;
   end

endmodule

`default_nettype wire

/* rtl/psu_queue.sv */
// ----------------------------------------------------------------------------
// psu_queue
// Short FIFO of classified data bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_queue
   import psu_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   output logic      full,
   output logic      head_valid,
   output item_type  head_item,
   input  wire logic pop
);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = entry_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue pushed while full");
`endif

endmodule

`default_nettype wire

/* rtl/psu_back.sv */
// ----------------------------------------------------------------------------
// psu_back
// Reconstructs queued bytes against the line buffer and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_back
   import psu_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  q_valid,
   input  item_type   q_item,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   output logic [7:0] rsp_tdata,   // pixel_byte
   output logic       rsp_tlast,   // row_end
   output logic [1:0] rsp_tuser    // [0] frame_end, [1] bad_filter
);

   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [10:0] sa, sb, sc, da, db, dc;
      logic        [10:0] pa, pb, pc;
      logic        [7:0]  pick;
      sa = signed'({3'b000, a});
      sb = signed'({3'b000, b});
      sc = signed'({3'b000, c});
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - sc - sc;
      pa = (da < 0) ? unsigned'(-da) : unsigned'(da);
      pb = (db < 0) ? unsigned'(-db) : unsigned'(db);
      pc = (dc < 0) ? unsigned'(-dc) : unsigned'(dc);
      priority if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

   logic       b_valid_ff, b_valid_in;
   item_type   b_item_ff;
   logic       fwd_hit_ff;
   logic [7:0] fwd_data_ff;
   logic [7:0] left_hist_ff [PIXEL_BYTES];
   logic [7:0] upleft_hist_ff [PIXEL_BYTES];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pixel_ff;
   logic       rsp_row_end_ff;
   logic       rsp_frame_end_ff;
   logic       rsp_bad_ff;

   logic       out_free;
   logic       advance;
   logic [7:0] ram_rdata;
   logic [7:0] left, up, upleft;
   logic [8:0] avg_sum;
   logic [7:0] pred;
   logic [7:0] recon;
   logic       bad;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance  = b_valid_ff && out_free;
   assign q_pop    = q_valid && (!b_valid_ff || advance);

   psu_ram #(
      .WIDTH (8),
      .DEPTH (LINE_BYTES)
   ) u_line_ram (
      .clock (clock),
      .we    (advance),
      .waddr (b_item_ff.col),
      .wdata (recon),
      .re    (q_pop),
      .raddr (q_item.col),
      .rdata (ram_rdata)
   );

   always_comb begin
      left    = b_item_ff.first_px ? 8'd0 : left_hist_ff[b_item_ff.lane];
      upleft  = b_item_ff.first_px ? 8'd0 : upleft_hist_ff[b_item_ff.lane];
      up      = b_item_ff.first_row ? 8'd0 : (fwd_hit_ff ? fwd_data_ff : ram_rdata);
      avg_sum = {1'b0, left} + {1'b0, up};
      bad     = 1'b0;
      unique case (b_item_ff.filter)
         FLT_NONE:  pred = 8'd0;
         FLT_SUB:   pred = left;
         FLT_UP:    pred = up;
         FLT_AVG:   pred = avg_sum[8:1];
         FLT_PAETH: pred = paeth_pick(left, up, upleft);
         default: begin
            pred = 8'd0;
            bad  = 1'b1;
         end
      endcase
      recon = b_item_ff.data + pred;
   end

   always_comb begin
      b_valid_in   = q_pop ? 1'b1 : (advance ? 1'b0 : b_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // same-address write in the cycle of the read: the RAM returns old data
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_item_ff   <= q_item;
         fwd_hit_ff  <= advance && (b_item_ff.col == q_item.col);
         fwd_data_ff <= recon;
      end
      if (advance) begin
         left_hist_ff[b_item_ff.lane]   <= recon;
         upleft_hist_ff[b_item_ff.lane] <= up;
         rsp_pixel_ff     <= bad ? 8'd0 : recon;
         rsp_row_end_ff   <= b_item_ff.last_col;
         rsp_frame_end_ff <= b_item_ff.last_col && b_item_ff.last_row;
         rsp_bad_ff       <= bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_row_end_ff;
   assign rsp_tuser  = {rsp_bad_ff, rsp_frame_end_ff};

`ifndef SYNTHESIS
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !advance |=> b_valid_ff && $stable(b_item_ff))
      else $error("reconstruct stage changed while stalled");
   a_frame_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_end_ff |-> rsp_row_end_ff)
      else $error("frame end without row end");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      advance && bad |=> rsp_valid_ff && rsp_bad_ff && rsp_pixel_ff == 8'd0)
      else $error("bad filter beat carries pixel data");
`endif

endmodule

`default_nettype wire

/* rtl/png_scanline_unfilter_unit.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit
// PNG scanline reconstruction (None, Sub, Up, Average, Paeth), byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries the filtered stream, one byte per beat: a filter-type byte
//  opening each row, then image_width * PIXEL_BYTES data bytes. The type
//  byte produces no rsp beat; every data byte produces exactly one.
//  rsp_* returns the reconstructed byte, tlast on the last byte of a row,
//  tuser[0] on the last byte of the frame, tuser[1] for rows with an
//  unknown type (pixel data forced to zero, raw byte kept as the row above).
//  csr_* writes image_width (index 0) and image_height (index 1); write
//  only while no beat is in flight.
//  Throughput: one beat per cycle while rsp is not stalled, set by the
//  reconstruct stage with its single line RAM read and write port. A data
//  byte passes the queue entry, then the reconstruct stage with its RAM
//  read, into the output register before it shows on rsp.
//  A stalled rsp holds its beat; req keeps being taken until the four-entry
//  queue fills, then req_tready drops. Synchronous reset empties the
//  pipeline, restores both registers to 1 and awaits a type byte; the line
//  RAM needs no clearing since the first row never reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter_unit
   import psu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // stream_byte
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,   // pixel_byte
   output logic                        rsp_tlast,   // row_end
   output logic [1:0]                  rsp_tuser    // [0] frame_end, [1] bad_filter
);

   logic     q_push;
   item_type q_push_item;
   logic     q_full;
   logic     q_valid;
   item_type q_head;
   logic     q_pop;

   psu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   psu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .head_valid (q_valid),
      .head_item  (q_head),
      .pop        (q_pop)
   );

   psu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
